// ----- rtl/lmfs_pkg.sv -----
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types, constants and helpers for the LED matrix frame store.
// ----------------------------------------------------------------------------
package lmfs_pkg;

  localparam int DEF_PANEL_WIDTH  = 8;
  localparam int DEF_PANEL_HEIGHT = 8;

  localparam int CFG_DATA_W = 10;

  localparam logic [7:0] BRIGHT_RESET = 8'd255;
  localparam logic [9:0] GAP_RESET    = 10'd100;
  localparam logic [15:0] ROUND_BIAS  = 16'd127;

  // register indexes on the configuration port
  localparam logic CFG_BRIGHTNESS = 1'b0;
  localparam logic CFG_FRAME_GAP  = 1'b1;

  typedef enum logic [1:0] {
    CMD_SET_PIXEL = 2'd0,
    CMD_CLEAR     = 2'd1,
    CMD_SHOW      = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] col_x;
    logic [7:0] row_y;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] led_word;
    logic        last_word;
    logic        busy_res;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;      // latch item, register channel products
    logic wr_pix;       // write scaled pixel if on the panel
    logic clr;          // drop every stored entry
    logic tick;         // millisecond tick on the gap counter
    logic gap_load;     // show accepted: restart gap
    logic idx_clr;
    logic idx_inc;
    logic rd_en;        // read store at scan index
    logic out_word;     // load output register with scanned word
    logic out_busy;     // load output register with busy result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic gap_zero;
    logic idx_last;
    logic out_free;
  } dp_stat_t;

  // exact p / 255 (callers add the 127 bias to round) for p below 65280
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ----- rtl/lmfs_dp.sv -----
// ----------------------------------------------------------------------------
// lmfs_dp
// Datapath: config registers, channel scaling, frame store, gap counter and
// output register.
// ----------------------------------------------------------------------------
module lmfs_dp import lmfs_pkg::*; #(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]  bright_r;
  logic [9:0]  gap_cfg_r;
  logic [9:0]  gap_r;

  logic [15:0] red_p_r, green_p_r, blue_p_r;
  logic [7:0]  x_r, y_r;

  logic [23:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [23:0]      rd_data_r;
  logic             rd_valid_r;

  logic [IDX_W-1:0] idx_r;
  logic [15:0]      pix_full;
  logic [IDX_W-1:0] pix_idx;
  logic             pix_ok;
  logic [23:0]      pix_val;

  logic      out_valid_r;
  out_item_t out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r  <= BRIGHT_RESET;
      gap_cfg_r <= GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BRIGHTNESS: bright_r  <= cfg_wdata[7:0];
        CFG_FRAME_GAP:  gap_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // first stage of a set-pixel: products plus rounding bias
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      red_p_r   <= {8'd0, in_data.red_in}   * {8'd0, bright_r} + ROUND_BIAS;
      green_p_r <= {8'd0, in_data.green_in} * {8'd0, bright_r} + ROUND_BIAS;
      blue_p_r  <= {8'd0, in_data.blue_in}  * {8'd0, bright_r} + ROUND_BIAS;
      x_r       <= in_data.col_x;
      y_r       <= in_data.row_y;
    end
  end

  // column-major placement
  assign pix_full = {8'd0, x_r} * 16'(PANEL_HEIGHT) + {8'd0, y_r};
  assign pix_idx  = pix_full[IDX_W-1:0];
  assign pix_ok   = (x_r < 8'(PANEL_WIDTH)) && (y_r < 8'(PANEL_HEIGHT));
  assign pix_val  = {div255(red_p_r), div255(green_p_r), div255(blue_p_r)};

  always_ff @(posedge clk) begin
    if (cmd.wr_pix && pix_ok) begin
      mem[pix_idx] <= pix_val;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_r];
    end
  end

  // an entry never written since reset or clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      valid_r <= '0;
    end else if (cmd.wr_pix && pix_ok) begin
      valid_r[pix_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (cmd.rd_en) begin
      rd_valid_r <= valid_r[idx_r];
    end
  end

  // scan index
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // frame gap counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (cmd.gap_load) begin
      gap_r <= gap_cfg_r;
    end else if (cmd.tick && gap_r != '0) begin
      gap_r <= gap_r - 10'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_word || cmd.out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_word) begin
      out_data_r.led_word  <= rd_valid_r ? {rd_data_r, 8'd0} : 32'd0;
      out_data_r.last_word <= stat.idx_last;
      out_data_r.busy_res  <= 1'b0;
    end else if (cmd.out_busy) begin
      out_data_r.led_word  <= 32'd0;
      out_data_r.last_word <= 1'b0;
      out_data_r.busy_res  <= 1'b1;
    end
  end

  assign stat.gap_zero = (gap_r == '0);
  assign stat.idx_last = (idx_r == IDX_W'(DEPTH - 1));
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_word || cmd.out_busy) |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_gap_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gap_load |=> (gap_r == $past(gap_cfg_r)))
    else $error("gap counter not restarted on show");

  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.busy_res) |->
      (out_data_r.led_word == 32'd0 && !out_data_r.last_word))
    else $error("busy result carries pixel data");

  a_rd_wr_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_en && (cmd.wr_pix || cmd.clr)))
    else $error("store scanned while being modified");

endmodule

// ----- rtl/lmfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lmfs_ctrl
// Controller: decodes accepted items and sequences set-pixel and show scans.
// ----------------------------------------------------------------------------
module lmfs_ctrl import lmfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cmd_t     in_cmd,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SET  = 5'b00010,
    S_RD   = 5'b00100,
    S_LD   = 5'b01000,
    S_BUSY = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_SET_PIXEL: begin
              cmd.load_in = 1'b1;
              state_nxt   = S_SET;
            end
            CMD_CLEAR: cmd.clr = 1'b1;
            CMD_SHOW: begin
              if (stat.gap_zero) begin
                cmd.gap_load = 1'b1;
                cmd.idx_clr  = 1'b1;
                state_nxt    = S_RD;
              end else begin
                state_nxt = S_BUSY;
              end
            end
            CMD_TICK: cmd.tick = 1'b1;
            default: ;
          endcase
        end
      end
      S_SET: begin
        cmd.wr_pix = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        if (stat.out_free) begin
          cmd.out_word = 1'b1;
          if (stat.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      S_BUSY: begin
        if (stat.out_free) begin
          cmd.out_busy = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_show_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_SHOW && stat.gap_zero) |=> (state_r == S_RD))
    else $error("accepted show did not start a scan");

  a_early_show_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_SHOW && !stat.gap_zero) |=> (state_r == S_BUSY))
    else $error("early show not refused");

  a_set_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_SET_PIXEL) |=> (cmd.wr_pix && !in_ready))
    else $error("set-pixel write not issued after accept");

endmodule

// ----- rtl/led_matrix_frame_store.sv -----
// ----------------------------------------------------------------------------
// led_matrix_frame_store
// RGB frame store for a small LED matrix with brightness scaling and a
// rate-limited show scan.
// ----------------------------------------------------------------------------
// Input items (in_valid/in_ready) carry a command: set pixel, clear, show or a
// millisecond tick. Set pixel registers the channel products, then writes the
// store; clear and tick are carried out as they are accepted. Off-panel pixels
// are dropped without any result.
// A show with the frame gap elapsed emits PANEL_WIDTH*PANEL_HEIGHT words on
// out_valid/out_ready, the last marked with last_word; each word is a store
// read, then an output register load. An early show returns one item with
// busy_res set and no pixel data.
// Results leave through an output register: a stalled receiver holds the
// scan, and the next input item is taken while the final result still waits.
// Reset clears the store at once (per-entry valid bits), the gap counter to
// zero, and the registers to brightness 255 and a gap of 100 ticks.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes a register
// directly and should be used only while the block is idle.
// ----------------------------------------------------------------------------
module led_matrix_frame_store import lmfs_pkg::*; #(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  lmfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_data.cmd),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  lmfs_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
